### rtl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg: shared types and constants of the ascii integer parser
// Holds the scan phase codes, status codes, register indexes and the digit
// decode used by the scan stage.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int unsigned RadixW = 6;
  localparam int unsigned ValueW = 64;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 64;

  // scan phase codes
  localparam logic [1:0] PH_FIRST   = 2'd0;
  localparam logic [1:0] PH_SIGN    = 2'd1;
  localparam logic [1:0] PH_DIGITS  = 2'd2;
  localparam logic [1:0] PH_STOPPED = 2'd3;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_RADIX      = 2'd0;
  localparam logic [1:0] REG_VALUE_LIM  = 2'd1;
  localparam logic [1:0] REG_FORCE_NEG  = 2'd2;

  localparam logic [RadixW-1:0] RadixMin   = 6'd2;
  localparam logic [RadixW-1:0] RadixMax   = 6'd36;
  localparam logic [RadixW-1:0] RadixReset = 6'd10;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] NO_DIGIT = 8'hff;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_INVALID = 2'd2
  } aip_status_e;

  typedef struct packed {
    logic [RadixW-1:0] radix;
    logic [ValueW-1:0] value_limit;
    logic              force_negative;
  } aip_cfg_t;

  // scan state captured at the end beat
  typedef struct packed {
    logic [ValueW-1:0] acc;
    logic [1:0]        phase;
    logic              neg;
    logic              ovf;
    logic              inv;
    logic              skip;
    logic              bad_radix;
  } aip_final_t;

  // digit value 0..35 of a byte, or NO_DIGIT
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      d = c - 8'h57;
    end
    return d;
  endfunction

endpackage

### rtl/aip_in_if.sv
// ----------------------------------------------------------------------------
// aip_in_if: byte channel into the parser
// Carries one byte of the numeral per beat with its end and empty flags.
// ----------------------------------------------------------------------------
interface aip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  logic       empty_text;

  modport source (output valid, output text_byte, output end_of_text,
                  output empty_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text,
                  input empty_text, output ready);
endinterface

### rtl/aip_out_if.sv
// ----------------------------------------------------------------------------
// aip_out_if: result channel out of the parser
// Carries one parsed value and its status per beat.
// ----------------------------------------------------------------------------
interface aip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] parsed_value;
  logic [1:0]  status;

  modport source (output valid, output parsed_value, output status, input ready);
  modport sink   (input valid, input parsed_value, input status, output ready);
endinterface

### rtl/aip_cfg_regs.sv
// ----------------------------------------------------------------------------
// aip_cfg_regs: configuration registers behind the apb port
// radix at 0x00, value_limit at 0x08, force_negative at 0x10.
// ----------------------------------------------------------------------------
module aip_cfg_regs
  import aip_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output aip_cfg_t         cfg_o
);

  logic [RadixW-1:0] radix_q;
  logic [ValueW-1:0] limit_q;
  logic              force_neg_q;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RadixReset;
      limit_q     <= '1;
      force_neg_q <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RADIX:     radix_q     <= pwdata[RadixW-1:0];
        REG_VALUE_LIM: limit_q     <= pwdata[ValueW-1:0];
        REG_FORCE_NEG: force_neg_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RADIX:     prdata = {{(DataW-RadixW){1'b0}}, radix_q};
      REG_VALUE_LIM: prdata = limit_q;
      REG_FORCE_NEG: prdata = {{(DataW-1){1'b0}}, force_neg_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.radix          = radix_q;
  assign cfg_o.value_limit    = limit_q;
  assign cfg_o.force_negative = force_neg_q;

endmodule

### rtl/aip_scan.sv
// ----------------------------------------------------------------------------
// aip_scan: input register and per-byte scan
// Registers the incoming beat, folds it into the accumulator and flags, and
// hands the final scan state to the finish stage on the end beat.
// ----------------------------------------------------------------------------
module aip_scan
  import aip_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  aip_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       empty_text_i,
  output logic       fin_valid_o,
  input  logic       fin_ready_i,
  output aip_final_t fin_o
);

  // input register
  logic       s0_valid_q;
  logic [7:0] s0_byte_q;
  logic       s0_end_q;
  logic       s0_empty_q;
  logic       s0_fire;

  // scan state
  logic [ValueW-1:0] acc_q, acc_d;
  logic [1:0]        phase_q, phase_d;
  logic              neg_q, neg_d;
  logic              ovf_q, ovf_d;
  logic              inv_q, inv_d;
  logic              skip_q, skip_d;

  // handoff register
  logic       s1_valid_q;
  aip_final_t s1_q;
  logic       s1_free;

  logic [7:0]        dig;
  logic              do_digit;
  logic [ValueW+6:0] mac;

  assign s1_free    = !s1_valid_q || fin_ready_i;
  assign s0_fire    = s0_valid_q && (!s0_end_q || s1_free);
  assign in_ready_o = !s0_valid_q || s0_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s0_byte_q  <= text_byte_i;
      s0_end_q   <= end_of_text_i;
      s0_empty_q <= empty_text_i;
    end
  end

  assign dig = digit_of(s0_byte_q);
  assign mac = (ValueW+7)'(acc_q) * (ValueW+7)'(cfg_i.radix) + (ValueW+7)'(dig);

  always_comb begin
    acc_d    = acc_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    ovf_d    = ovf_q;
    inv_d    = inv_q;
    skip_d   = skip_q;
    do_digit = 1'b0;
    // an empty end beat carries no byte
    if (!(s0_end_q && s0_empty_q) && phase_q != PH_STOPPED) begin
      if (phase_q == PH_FIRST) begin
        neg_d = cfg_i.force_negative;
        if (s0_byte_q == CH_MINUS) begin
          neg_d   = 1'b1;
          phase_d = PH_SIGN;
        end else begin
          do_digit = 1'b1;
        end
      end else if (skip_q) begin
        skip_d   = 1'b0;
        do_digit = 1'b1;
      end else if (s0_byte_q == CH_UNDER && !s0_end_q) begin
        skip_d = 1'b1;
      end else begin
        do_digit = 1'b1;
      end
    end
    if (do_digit) begin
      if (dig != NO_DIGIT && dig < {2'b00, cfg_i.radix}) begin
        if (!ovf_q) begin
          if (mac[ValueW+6:ValueW] != '0) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = mac[ValueW-1:0];
          end
        end
        phase_d = PH_DIGITS;
      end else begin
        inv_d   = 1'b1;
        phase_d = PH_STOPPED;
      end
    end
  end

  // state clears after the end beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      phase_q <= PH_FIRST;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      inv_q   <= 1'b0;
      skip_q  <= 1'b0;
    end else if (s0_fire) begin
      if (s0_end_q) begin
        acc_q   <= '0;
        phase_q <= PH_FIRST;
        neg_q   <= 1'b0;
        ovf_q   <= 1'b0;
        inv_q   <= 1'b0;
        skip_q  <= 1'b0;
      end else begin
        acc_q   <= acc_d;
        phase_q <= phase_d;
        neg_q   <= neg_d;
        ovf_q   <= ovf_d;
        inv_q   <= inv_d;
        skip_q  <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= s0_fire && s0_end_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_fire && s0_end_q) begin
      s1_q.acc       <= acc_d;
      s1_q.phase     <= phase_d;
      s1_q.neg       <= neg_d;
      s1_q.ovf       <= ovf_d;
      s1_q.inv       <= inv_d;
      s1_q.skip      <= skip_d;
      s1_q.bad_radix <= (cfg_i.radix < RadixMin) || (cfg_i.radix > RadixMax);
    end
  end

  assign fin_valid_o = s1_valid_q;
  assign fin_o       = s1_q;

endmodule

### rtl/aip_finish.sv
// ----------------------------------------------------------------------------
// aip_finish: range clamp, sign and result register
// Turns the final scan state into value and status and holds them until the
// result beat is taken.
// ----------------------------------------------------------------------------
module aip_finish
  import aip_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aip_cfg_t          cfg_i,
  input  logic              fin_valid_i,
  output logic              fin_ready_o,
  input  aip_final_t        fin_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValueW-1:0] value_o,
  output logic [1:0]        status_o
);

  logic              out_valid_q;
  logic [ValueW-1:0] value_q, value_d;
  aip_status_e       status_q, status_d;
  logic              out_free;

  logic              inv;
  logic              neg;
  logic              lim_odd;
  logic [ValueW-1:0] y;
  logic [ValueW-1:0] y_signed;

  assign out_free    = !out_valid_q || out_ready_i;
  assign fin_ready_o = out_free;
  assign lim_odd     = cfg_i.value_limit[0];

  always_comb begin
    inv      = fin_i.inv || fin_i.skip || (fin_i.phase == PH_SIGN);
    y        = fin_i.ovf ? cfg_i.value_limit : fin_i.acc;
    neg      = fin_i.neg && !(fin_i.ovf && lim_odd);
    y_signed = neg ? (ValueW'(0) - y) : y;
    value_d  = '0;
    status_d = fin_i.ovf ? ST_RANGE : ST_OK;
    priority if (fin_i.phase == PH_FIRST) begin
      status_d = ST_INVALID;
    end else if (fin_i.bad_radix) begin
      status_d = ST_RANGE;
    end else if (inv) begin
      status_d = ST_INVALID;
      value_d  = y_signed;
    end else if (y >= cfg_i.value_limit && !lim_odd && !neg) begin
      // signed-style limit, positive side
      status_d = ST_RANGE;
      value_d  = cfg_i.value_limit - ValueW'(1);
    end else if (y > cfg_i.value_limit) begin
      status_d = ST_RANGE;
      value_d  = cfg_i.value_limit;
    end else begin
      value_d  = y_signed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fin_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fin_valid_i) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

### rtl/ascii_integer_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser_unit: byte-serial integer scanner, bases 2 to 36
// Accumulates the digits of a numeral one byte per beat and returns a 64-bit
// value with an ok / out-of-range / invalid status on the end beat.
// ----------------------------------------------------------------------------
// The unit takes one byte beat every clock cycle unless a stalled result
// holds it back. Each byte is registered, then folded into the 64-bit
// accumulator by one multiply-add with the configured radix (a 64 by 6 bit
// product); that accumulator loop sets the byte rate. Only the beat flagged
// end_of_text produces a result: it is scanned into the handoff register,
// then clamped and signed into the result register, and these two registers
// let new bytes keep flowing while a result waits to be taken. A leading
// minus sign is honoured, as is force_negative; an underscore escapes the
// next byte; the first non-digit stops the scan and flags invalid input.
// Overflow and magnitudes above value_limit are clamped, as is a positive one
// at an even limit: odd limits behave unsigned-style, even ones signed-style.
// Registers are to be written over the apb port only while no string is in
// flight: a rule on the user that the block itself does not enforce.
// ----------------------------------------------------------------------------
module ascii_integer_parser_unit
  import aip_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // apb configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  // byte beats in, result beats out
  aip_in_if.sink           in_i,
  aip_out_if.source        out_o
);

  aip_cfg_t   cfg;
  logic       fin_valid;
  logic       fin_ready;
  aip_final_t fin;
  logic [1:0] status_raw;

  // register file
  aip_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register, accumulator and scan flags
  aip_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .text_byte_i   (in_i.text_byte),
    .end_of_text_i (in_i.end_of_text),
    .empty_text_i  (in_i.empty_text),
    .fin_valid_o   (fin_valid),
    .fin_ready_i   (fin_ready),
    .fin_o         (fin)
  );

  // clamp, sign and result register
  aip_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fin_valid_i (fin_valid),
    .fin_ready_o (fin_ready),
    .fin_i       (fin),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .value_o     (out_o.parsed_value),
    .status_o    (status_raw)
  );

  assign out_o.status = status_raw;

  // only three status codes exist
  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.status != 2'd3))
    else $error("undefined status code on result beat");

  // input back-pressure only ever comes from a stalled result
  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with no result pending");

  // with an odd limit an out-of-range result is the limit or the bad-radix zero
  a_odd_limit_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_RANGE && cfg.value_limit[0])
      |-> (out_o.parsed_value == cfg.value_limit || out_o.parsed_value == '0))
    else $error("out-of-range value differs from the odd limit");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ascii integer parser
// Streams numerals byte by byte under a range of radix, limit and sign
// settings, predicts each end-of-text result in the bench unless a directed
// row types it in, and checks every result beat field by field, with random
// idling on both channels and one long stall on the result side.
// ----------------------------------------------------------------------------
module tb
  import aip_pkg::*;
();

  // one byte beat as offered on the input channel
  typedef struct packed {
    logic [7:0] c;
    logic       eot;
    logic       emp;
  } text_beat_t;

  // what an end beat is expected to return
  typedef struct packed {
    logic [ValueW-1:0] value;
    aip_status_e       status;
  } parse_result_t;

  // directed row: a byte beat, with the result typed in where it is obvious
  typedef struct {
    logic [7:0]        c;
    logic              eot;
    logic              emp;
    logic              typed;
    logic [ValueW-1:0] value;
    aip_status_e       status;
  } opening_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  // apb configuration port
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  aip_in_if  byte_if ();
  aip_out_if res_if ();

  ascii_integer_parser_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (byte_if),
    .out_o   (res_if)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // bench copy of the configuration and of the scan state
  // --------------------------------------------------------------------------
  aip_cfg_t          scan_cfg;
  logic [ValueW-1:0] acc_q;
  logic [1:0]        phase_q;
  logic              neg_q;
  logic              ovf_q;
  logic              inv_q;
  logic              skip_q;

  // results still owed by the block, oldest first
  parse_result_t awaited_results [$];
  int unsigned   fault_count;

  // flow control knobs set per phase by the main sequence
  bit steady_flow;
  bit hold_request;

  // --------------------------------------------------------------------------
  // directed opening: sign, underscore escapes, garbage and empty strings
  // --------------------------------------------------------------------------
  opening_row_t opening_rows [22] = '{
    // empty string
    '{8'h00,    1'b1, 1'b1, 1'b1, 64'd0, ST_INVALID},
    // single zero digit
    '{8'h30,    1'b1, 1'b0, 1'b1, 64'd0, ST_OK},
    // lone minus sign, no digit behind it
    '{CH_MINUS, 1'b1, 1'b0, 1'b1, 64'd0, ST_INVALID},
    // minus five
    '{CH_MINUS, 1'b0, 1'b0, 1'b0, 64'd0, ST_OK},
    '{8'h35,    1'b1, 1'b0, 1'b1, 64'hffff_ffff_ffff_fffb, ST_OK},
    // underscore as the final byte is a literal, bad byte
    '{8'h37,    1'b0, 1'b0, 1'b0, 64'd0, ST_OK},
    '{CH_UNDER, 1'b1, 1'b0, 1'b1, 64'd7, ST_INVALID},
    // escape left hanging by an empty end beat
    '{8'h31,    1'b0, 1'b0, 1'b0, 64'd0, ST_OK},
    '{CH_UNDER, 1'b0, 1'b0, 1'b0, 64'd0, ST_OK},
    '{8'h00,    1'b1, 1'b1, 1'b1, 64'd1, ST_INVALID},
    // all-ones byte is just another bad byte
    '{8'hff,    1'b1, 1'b0, 1'b1, 64'd0, ST_INVALID},
    // garbage after digits stops the scan
    '{8'h39,    1'b0, 1'b0, 1'b0, 64'd0, ST_OK},
    '{8'h78,    1'b0, 1'b0, 1'b0, 64'd0, ST_OK},
    '{8'h35,    1'b1, 1'b1, 1'b1, 64'd9, ST_INVALID},
    // underscore in first place is not an escape
    '{CH_UNDER, 1'b0, 1'b0, 1'b0, 64'd0, ST_OK},
    '{8'h35,    1'b1, 1'b0, 1'b1, 64'd0, ST_INVALID},
    // escaped digit in mid string
    '{8'h31,    1'b0, 1'b0, 1'b0, 64'd0, ST_OK},
    '{CH_UNDER, 1'b0, 1'b0, 1'b0, 64'd0, ST_OK},
    '{8'h32,    1'b1, 1'b0, 1'b0, 64'd0, ST_OK},
    // empty flag without end of text, byte still taken
    '{8'h33,    1'b0, 1'b1, 1'b0, 64'd0, ST_OK},
    '{8'h34,    1'b1, 1'b0, 1'b0, 64'd0, ST_OK},
    // letter above the decimal radix
    '{8'h5a,    1'b1, 1'b0, 1'b1, 64'd0, ST_INVALID}
  };

  // radix, limit and sign settings walked after the opening
  aip_cfg_t phase_cfgs [10] = '{
    '{6'd36, 64'hffff_ffff_ffff_ffff, 1'b0},
    '{6'd2,  64'hffff_ffff_ffff_ffff, 1'b1},
    '{6'd10, 64'h8000_0000_0000_0000, 1'b0},
    '{6'd16, 64'h0,                   1'b0},
    '{6'd8,  64'h1,                   1'b1},
    '{6'd10, 64'h7fff_ffff_ffff_ffff, 1'b0},
    '{6'd0,  64'd100,                 1'b0},
    '{6'd1,  64'd100,                 1'b1},
    '{6'd37, 64'hffff_ffff_ffff_ffff, 1'b0},
    '{6'd63, 64'd2,                   1'b0}
  };

  function automatic text_beat_t text_beat(input logic [7:0] c, input logic eot,
                                           input logic emp);
    text_beat_t b;
    b.c   = c;
    b.eot = eot;
    b.emp = emp;
    return b;
  endfunction

  // digit value 0..35, or the no-digit code
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h5a) return c - 8'h41 + 8'd10;
    if (c >= 8'h61 && c <= 8'h7a) return c - 8'h61 + 8'd10;
    return NO_DIGIT;
  endfunction

  function void restart_scan();
    acc_q   = '0;
    phase_q = PH_FIRST;
    neg_q   = scan_cfg.force_negative;
    ovf_q   = 1'b0;
    inv_q   = 1'b0;
    skip_q  = 1'b0;
  endfunction

  // multiply-add of one digit, or stop on a non-digit
  function void fold_char(input logic [7:0] c);
    logic [ValueW-1:0] d;
    logic [ValueW-1:0] r;
    d = {56'd0, digit_value(c)};
    r = {{(ValueW-RadixW){1'b0}}, scan_cfg.radix};
    if (d < r) begin
      if (!ovf_q) begin
        // the step would leave 64 bits: mark it and stop adding
        if (acc_q > ({ValueW{1'b1}} - d) / r) begin
          ovf_q = 1'b1;
        end else begin
          acc_q = acc_q * r + d;
        end
      end
      phase_q = PH_DIGITS;
    end else begin
      inv_q   = 1'b1;
      phase_q = PH_STOPPED;
    end
  endfunction

  function void scan_byte(input logic [7:0] c, input logic last);
    if (phase_q == PH_STOPPED) return;
    if (phase_q == PH_FIRST) begin
      neg_q = scan_cfg.force_negative;
      if (c == CH_MINUS) begin
        neg_q   = 1'b1;
        phase_q = PH_SIGN;
      end else begin
        fold_char(c);
      end
      return;
    end
    if (skip_q) begin
      // escaped byte is taken literally
      skip_q = 1'b0;
      fold_char(c);
      return;
    end
    if (c == CH_UNDER && !last) begin
      skip_q = 1'b1;
      return;
    end
    fold_char(c);
  endfunction

  // advance the bench scan by one beat; an end beat yields a result
  task automatic scan_text_beat(input logic [7:0] c, input logic eot, input logic emp,
                                output bit made, output parse_result_t res);
    logic [ValueW-1:0] y;
    logic [ValueW-1:0] lim;
    logic              neg;
    res.value  = '0;
    res.status = ST_OK;
    made       = 1'b0;
    lim        = scan_cfg.value_limit;
    if (!eot) begin
      scan_byte(c, 1'b0);
    end else begin
      if (!emp) scan_byte(c, 1'b1);
      made = 1'b1;
      if (phase_q == PH_FIRST) begin
        // nothing was ever scanned
        res.status = ST_INVALID;
      end else if (scan_cfg.radix < RadixMin || scan_cfg.radix > RadixMax) begin
        res.status = ST_RANGE;
      end else begin
        // hanging escape or bare sign count as bad input
        if (skip_q || phase_q == PH_SIGN) inv_q = 1'b1;
        y   = acc_q;
        neg = neg_q;
        if (ovf_q) begin
          res.status = ST_RANGE;
          y          = lim;
          if (lim[0]) neg = 1'b0;
        end
        if (inv_q) begin
          res.status = ST_INVALID;
          res.value  = neg ? -y : y;
        end else if (y >= lim && !lim[0] && !neg) begin
          // signed-style limit: positive side tops out one below it
          res.status = ST_RANGE;
          res.value  = lim - 1'b1;
        end else if (y > lim) begin
          res.status = ST_RANGE;
          res.value  = lim;
        end else begin
          res.value = neg ? -y : y;
        end
      end
      restart_scan();
    end
  endtask

  // --------------------------------------------------------------------------
  // channel and register access
  // --------------------------------------------------------------------------
  task automatic reg_write(input logic [1:0] idx, input logic [DataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RADIX:     scan_cfg.radix          = data[RadixW-1:0];
      REG_VALUE_LIM: scan_cfg.value_limit    = data[ValueW-1:0];
      REG_FORCE_NEG: scan_cfg.force_negative = data[0];
      default: ;
    endcase
  endtask

  // offer one byte beat, with random gaps ahead of it, and predict on accept
  task automatic send_beat(input text_beat_t b, input bit typed,
                           input parse_result_t typed_res);
    parse_result_t res;
    bit            made;
    while (!steady_flow && $urandom_range(0, 99) < 24) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid       <= 1'b1;
    byte_if.text_byte   <= b.c;
    byte_if.end_of_text <= b.eot;
    byte_if.empty_text  <= b.emp;
    do @(posedge clk_i); while (byte_if.ready !== 1'b1);
    scan_text_beat(b.c, b.eot, b.emp, made, res);
    if (made) awaited_results.push_back(typed ? typed_res : res);
  endtask

  // let every owed result drain, then give the pipe time to settle
  task automatic wait_quiet();
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // random numerals under the current setting
  // --------------------------------------------------------------------------
  task automatic run_phase(input int goal);
    text_beat_t        seq [$];
    logic [7:0]        digs [$];
    logic [ValueW-1:0] v;
    logic [ValueW-1:0] rr;
    logic [7:0]        ch;
    int                sent;
    int                mode;
    int                n;
    int                k;
    bit                good_radix;
    sent       = 0;
    rr         = {{(ValueW-RadixW){1'b0}}, scan_cfg.radix};
    good_radix = (scan_cfg.radix >= RadixMin && scan_cfg.radix <= RadixMax);
    while (sent < goal) begin
      seq.delete();
      digs.delete();
      mode = $urandom_range(0, 99);
      if (mode < 10) begin
        // noise: raw bytes with random flags
        n = $urandom_range(0, 5);
        repeat (n) seq.push_back(text_beat(8'($urandom_range(0, 255)), 1'b0,
                                           1'($urandom_range(0, 1))));
        seq.push_back(text_beat(8'($urandom_range(0, 255)), 1'b1,
                                1'($urandom_range(0, 1))));
      end else begin
        if ($urandom_range(0, 3) == 0) seq.push_back(text_beat(CH_MINUS, 1'b0, 1'b0));
        if (good_radix && mode < 45) begin
          // spell out a value near the limit or a corner of the range
          case ($urandom_range(0, 5))
            0:       v = scan_cfg.value_limit;
            1:       v = scan_cfg.value_limit - 1'b1;
            2:       v = scan_cfg.value_limit + 1'b1;
            3:       v = {$urandom, $urandom};
            4:       v = ValueW'($urandom_range(0, 1000));
            default: v = '1;
          endcase
          do begin
            digs.push_front(8'(v % rr));
            v = v / rr;
          end while (v != 0);
        end else begin
          if (good_radix) begin
            // digits needed to run past 64 bits in this radix
            v = '1;
            k = 0;
            while (v != 0) begin
              v = v / rr;
              k++;
            end
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(k - 1, k + 2)
                                            : $urandom_range(1, 6);
          end else begin
            n = $urandom_range(1, 24);
          end
          repeat (n) digs.push_back(8'($urandom_range(0, good_radix ? scan_cfg.radix - 1
                                                                    : 35)));
        end
        foreach (digs[i]) begin
          if ($urandom_range(0, 99) < 6) seq.push_back(text_beat(CH_UNDER, 1'b0, 1'b0));
          if ($urandom_range(0, 99) < 3) begin
            seq.push_back(text_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
          end
          if (digs[i] < 10) begin
            ch = 8'h30 + digs[i];
          end else begin
            ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + digs[i] - 8'd10;
          end
          seq.push_back(text_beat(ch, 1'b0, $urandom_range(0, 99) < 3));
        end
        // how the string ends
        case ($urandom_range(0, 9))
          0:       seq.push_back(text_beat(CH_UNDER, 1'b1, 1'b0));
          1:       seq.push_back(text_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1));
          2:       seq.push_back(text_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0));
          default: seq[seq.size()-1].eot = 1'b1;
        endcase
      end
      foreach (seq[i]) send_beat(seq[i], 1'b0, '0);
      sent += seq.size();
    end
    byte_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side: random back-pressure plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left    = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        // long stall so the block backs up and stops taking bytes
        hold_request = 1'b0;
        hold_left    = 300;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady_flow || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    parse_result_t exp_res;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result beat: value %h status %0d",
               res_if.parsed_value, res_if.status);
        fault_count++;
      end else begin
        exp_res = awaited_results.pop_front();
        if (res_if.parsed_value !== exp_res.value) begin
          $error("parsed_value mismatch: expected %h, actual %h",
                 exp_res.value, res_if.parsed_value);
          fault_count++;
        end
        if (res_if.status !== exp_res.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 exp_res.status, res_if.status);
          fault_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    parse_result_t typed_res;
    aip_cfg_t      cfg;
    fault_count  = 0;
    steady_flow  = 1'b0;
    hold_request = 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    byte_if.valid       <= 1'b0;
    byte_if.text_byte   <= '0;
    byte_if.end_of_text <= 1'b0;
    byte_if.empty_text  <= 1'b0;
    rst_ni  <= 1'b0;
    scan_cfg.radix          = RadixReset;
    scan_cfg.value_limit    = '1;
    scan_cfg.force_negative = 1'b0;
    restart_scan();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // opening rows at the reset settings
    foreach (opening_rows[i]) begin
      typed_res.value  = opening_rows[i].value;
      typed_res.status = opening_rows[i].status;
      send_beat(text_beat(opening_rows[i].c, opening_rows[i].eot, opening_rows[i].emp),
                opening_rows[i].typed, typed_res);
    end
    byte_if.valid <= 1'b0;

    // fixed corner settings, then a few drawn at random
    for (int p = 0; p < 13; p++) begin
      wait_quiet();
      if (p < 10) begin
        cfg = phase_cfgs[p];
      end else begin
        cfg.radix          = RadixW'($urandom_range(2, 36));
        cfg.value_limit    = {$urandom, $urandom} >> $urandom_range(0, 63);
        cfg.force_negative = 1'($urandom_range(0, 1));
      end
      reg_write(REG_RADIX, {{(DataW-RadixW){1'b0}}, cfg.radix});
      reg_write(REG_VALUE_LIM, cfg.value_limit);
      reg_write(REG_FORCE_NEG, {{(DataW-1){1'b0}}, cfg.force_negative});
      steady_flow  = (p == 0);
      hold_request = (p == 2);
      run_phase((cfg.radix >= RadixMin && cfg.radix <= RadixMax) ? 100 : 30);
    end

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #800000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### ascii_integer_parser_unit.f
rtl/aip_pkg.sv
rtl/aip_in_if.sv
rtl/aip_out_if.sv
rtl/aip_cfg_regs.sv
rtl/aip_scan.sv
rtl/aip_finish.sv
rtl/ascii_integer_parser_unit.sv
bench/tb.sv
